// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define CHK_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");

// Check that a condition implies a consequence in the next cycle.
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");

`endif

// ===== sv/alte_pkg.sv =====
// Package for the array list engine: request codes, status codes, beat types.
// Depends on nothing.
package alte_pkg;
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_LOCATE = 3'd2;
    localparam logic [2:0] REQ_RETRIEVE = 3'd3;
    localparam logic [2:0] REQ_SORTED = 3'd4;
    localparam logic [2:0] REQ_CLEAR = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [4:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         found_position;
        logic signed [31:0] read_value;
        logic [4:0]         entry_count;
    } t_rsp;
endpackage

// ===== sv/alte_front.sv =====
// Front part: accepts request beats into a two-entry queue.
// Depends on alte_pkg.
module alte_front import alte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_take,
    output t_req o_req
);
    t_req       r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_q[r_wr] <= i_req;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && !o_stall) begin
                r_wr <= !r_wr;
            end
            if (i_take && o_valid) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_valid && !o_stall) - 2'(i_take && o_valid);
        end
    end
endmodule

// ===== sv/alte_back.sv =====
// Back part: register-cell list that executes one request per pass.
// Depends on alte_pkg.
module alte_back import alte_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_take,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]   r_cell [CAPACITY];
    logic [CW-1:0] r_count;
    logic          r_busy;
    t_req          r_req;
    logic [CAPACITY-1:0] r_lt;
    logic [CAPACITY-1:0] r_eq;
    logic          r_ovalid;
    t_rsp          r_rsp;

    logic [CAPACITY-1:0] lt_v;
    logic [CAPACITY-1:0] eq_v;
    logic [CW-1:0] ins_idx;
    logic [CW-1:0] loc_idx;
    logic          loc_hit;
    logic [CW-1:0] pos_w;
    logic          do_ins;
    logic          do_del;
    logic [CW-1:0] tgt;
    t_rsp          n_rsp;
    logic [CW-1:0] n_count;

    assign o_take  = !r_busy && (!r_ovalid || !i_stall);
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    // Compare stage: every cell against the value at once.
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            lt_v[k] = (CW'(k) < r_count) && ($signed(r_cell[k]) < i_req.value);
            eq_v[k] = (CW'(k) < r_count) && (r_cell[k] == i_req.value);
        end
    end

    // Execute stage: priority searches over the registered compare bits, then the request decode that forms the result.
    always_comb begin
        ins_idx = r_count;
        loc_idx = '0;
        loc_hit = 1'b0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if ((CW'(k) < r_count) && !r_lt[k]) begin
                ins_idx = CW'(k);
            end
            if (r_eq[k]) begin
                loc_idx = CW'(k);
                loc_hit = 1'b1;
            end
        end
        pos_w   = CW'(r_req.position);
        do_ins  = 1'b0;
        do_del  = 1'b0;
        tgt     = '0;
        n_count = r_count;
        n_rsp   = '0;
        case (r_req.req_type)
            REQ_INSERT: begin
                if (r_count >= CW'(CAPACITY)) begin
                    n_rsp.status = ST_FULL;
                end else if (r_req.position == 5'd0 || {1'b0, pos_w} > r_count + 1'b1
                             || 32'(r_req.position) > CAPACITY) begin
                    n_rsp.status = ST_BAD;
                end else begin
                    do_ins  = 1'b1;
                    tgt     = pos_w - 1'b1;
                    n_count = r_count + 1'b1;
                    n_rsp.found_position = r_req.position;
                end
            end
            REQ_DELETE: begin
                if (r_req.position == 5'd0 || 32'(r_req.position) > 32'(r_count)) begin
                    n_rsp.status = ST_BAD;
                end else begin
                    do_del  = 1'b1;
                    tgt     = pos_w - 1'b1;
                    n_count = r_count - 1'b1;
                    n_rsp.found_position = r_req.position;
                end
            end
            REQ_LOCATE: begin
                if (loc_hit) begin
                    n_rsp.found_position = 5'(loc_idx + 1'b1);
                end else begin
                    n_rsp.status = ST_MISS;
                end
            end
            REQ_RETRIEVE: begin
                if (r_req.position == 5'd0 || 32'(r_req.position) > 32'(r_count)) begin
                    n_rsp.status = ST_BAD;
                end else begin
                    n_rsp.read_value     = r_cell[IW'(pos_w - 1'b1)];
                    n_rsp.found_position = r_req.position;
                end
            end
            REQ_SORTED: begin
                if (r_count >= CW'(CAPACITY)) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    tgt     = ins_idx;
                    n_count = r_count + 1'b1;
                    n_rsp.found_position = 5'(ins_idx + 1'b1);
                end
            end
            REQ_CLEAR: n_count = '0;
            default: ;
        endcase
        n_rsp.entry_count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_take) begin
            r_req <= i_req;
            r_lt  <= lt_v;
            r_eq  <= eq_v;
        end
        if (r_busy) begin
            r_rsp <= n_rsp;
            for (int k = 0; k < CAPACITY; k++) begin
                if (do_ins) begin
                    if (CW'(k) == tgt) begin
                        r_cell[k] <= r_req.value;
                    end else if (CW'(k) > tgt && k > 0) begin
                        r_cell[k] <= r_cell[(k > 0) ? k - 1 : 0];
                    end
                end else if (do_del && CW'(k) >= tgt && k < CAPACITY - 1) begin
                    r_cell[k] <= r_cell[(k < CAPACITY - 1) ? k + 1 : k];
                end
            end
        end
        if (!i_rst_n) begin
            r_count  <= '0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_busy) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            r_busy <= i_valid && o_take;
        end
    end
endmodule

// ===== sv/array_list_table_engine_core.sv =====
// Top level of the array list engine: request queue plus list executor.
// Depends on alte_pkg, alte_front and alte_back.
//
//   channel  direction  handshake                      payload
//   request  in         i_req_valid / o_req_stall      i_req (t_req)
//   result   out        o_rsp_valid / i_rsp_stall      o_rsp (t_rsp)
//
// In the list executor a request is compared with every cell and the compare bits
// are registered; then the cells shift and the result forms, before the next request is taken.
// One result beat per request, in request order.
// Reset is synchronous and clears the count, the queue and all valid flags.
// A stalled result holds the executor; the queue keeps accepting two beats.
module array_list_table_engine_core import alte_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);
    logic q_valid;
    logic q_take;
    t_req q_req;

    // The queue decouples acceptance from execution.
    alte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_stall (o_req_stall),
        .i_req   (i_req),
        .o_valid (q_valid),
        .i_take  (q_take),
        .o_req   (q_req)
    );

    // The executor holds the register-cell list and the entry count.
    alte_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_take  (q_take),
        .i_req   (q_req),
        .o_valid (o_rsp_valid),
        .i_stall (i_rsp_stall),
        .o_rsp   (o_rsp)
    );
endmodule

// ===== sv/alte_checker.sv =====
// Port-level checker for the array list engine, bound to the top level.
// Depends on alte_pkg and assert_macros.svh.
`include "assert_macros.svh"
module alte_checker import alte_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_stall,
    input t_rsp i_rsp
);
    // A rejected or missed request is shown by a nonzero status.
    logic rsp_err;
    assign rsp_err = i_rsp_valid && (i_rsp.status != ST_OK);

    `CHK_NEXT(a_hold, i_clk, i_rst_n, i_rsp_valid && i_rsp_stall, $stable(i_rsp))
    `CHK_SAME(a_miss_pos, i_clk, i_rst_n, rsp_err, i_rsp.found_position == 5'd0)
    `CHK_SAME(a_rd_zero, i_clk, i_rst_n, rsp_err, i_rsp.read_value == 32'sd0)
endmodule

bind array_list_table_engine_core alte_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .i_rsp       (o_rsp)
);
